[rtl/qte_pkg.sv]
// ----------------------------------------------------------------------------
// qte_pkg: shared types and constants for the quaternion to Euler angle unit
// Request payloads, CORDIC and square root cell data, angle table, rounding.
// ----------------------------------------------------------------------------
package qte_pkg;

  localparam int QW       = 16;            // input component width, Q1.15
  localparam int AW       = 16;            // output angle width, Q3.12
  localparam int DW       = 36;            // CORDIC datapath width, Q2.30 based
  localparam int SQW      = 62;            // square root operand width
  localparam int SQ_CELLS = 31;            // one cell per root bit
  localparam int RND_SH   = 30 - (AW - 4); // Q2.30 to output fraction
  localparam int TBL_N    = 32;

  localparam logic signed [DW-1:0] ONE_Q30     = 36'sd1073741824;
  localparam logic signed [DW-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [DW-1:0] HALF_PI_Q30 = 36'sd1686629713;

  localparam logic signed [DW-1:0] ATAN_TBL [TBL_N] = '{
    36'sd843314856, 36'sd497837829, 36'sd263043836, 36'sd133525158,
    36'sd67021686,  36'sd33543515,  36'sd16775850,  36'sd8388437,
    36'sd4194282,   36'sd2097149,   36'sd1048575,   36'sd524287,
    36'sd262143,    36'sd131071,    36'sd65535,     36'sd32767,
    36'sd16383,     36'sd8191,      36'sd4095,      36'sd2047,
    36'sd1023,      36'sd511,       36'sd255,       36'sd127,
    36'sd63,        36'sd31,        36'sd15,        36'sd8,
    36'sd4,         36'sd2,         36'sd1,         36'sd0
  };

  typedef enum logic [1:0] {
    LOCK_NONE  = 2'd0,
    LOCK_NORTH = 2'd1,
    LOCK_SOUTH = 2'd2
  } lock_t;

  typedef struct packed {
    logic signed [QW-1:0] quat_y;
    logic signed [QW-1:0] quat_x;
    logic signed [QW-1:0] quat_z;
    logic signed [QW-1:0] quat_w;
  } qte_in_t;

  typedef struct packed {
    logic signed [AW-1:0] yaw;
    logic signed [AW-1:0] pitch;
    logic signed [AW-1:0] roll;
    logic [1:0]           lock_case;
  } qte_out_t;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [DW-1:0] z;
    logic                 zero;
  } cordic_t;

  typedef struct packed {
    logic [SQW-1:0] n;
    logic [SQW-1:0] res;
  } sqrt_t;

  typedef struct packed {
    lock_t                lock;
    logic signed [DW-1:0] t;
    logic signed [DW-1:0] roll_y;
    logic signed [DW-1:0] roll_x;
    logic signed [DW-1:0] yaw_y;
    logic signed [DW-1:0] yaw_x;
  } side_t;

  // quadrant fold ahead of the rotation cells
  function automatic cordic_t cordic_pre(input logic signed [DW-1:0] y,
                                         input logic signed [DW-1:0] x);
    cordic_t r;
    r.zero = (x == '0) && (y == '0);
    if (x[DW-1]) begin
      r.z = y[DW-1] ? -PI_Q30 : PI_Q30;
      r.x = -x;
      r.y = -y;
    end else begin
      r.z = '0;
      r.x = x;
      r.y = y;
    end
    return r;
  endfunction

  // round half up from Q2.30, saturate to the output width
  function automatic logic signed [AW-1:0] angle_out(input logic signed [DW+1:0] z);
    logic signed [DW+1:0] v;
    v = (z + (DW+2)'(1 << (RND_SH - 1))) >>> RND_SH;
    if (v > (DW+2)'((1 << (AW - 1)) - 1)) begin
      return {1'b0, {(AW-1){1'b1}}};
    end else if (v < -(DW+2)'(1 << (AW - 1))) begin
      return {1'b1, {(AW-1){1'b0}}};
    end else begin
      return v[AW-1:0];
    end
  endfunction

endpackage

[rtl/qte_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// qte_sqrt_cell: one bit of a pipelined floor integer square root
// Trial subtract of res + 4^K from the remainder, then register.
// ----------------------------------------------------------------------------
module qte_sqrt_cell
  import qte_pkg::*;
#(
  parameter int K = 0
) (
  input  logic  clk,
  input  logic  en,
  input  sqrt_t din,
  output sqrt_t dout
);

  localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * K);

  logic [SQW-1:0] cand;
  sqrt_t          nxt;

  always_comb begin
    cand = din.res + BIT;
    if (din.n >= cand) begin
      nxt.n   = din.n - cand;
      nxt.res = (din.res >> 1) + BIT;
    end else begin
      nxt.n   = din.n;
      nxt.res = din.res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

[rtl/qte_cordic_cell.sv]
// ----------------------------------------------------------------------------
// qte_cordic_cell: one vectoring-mode CORDIC micro-rotation
// Rotates toward y = 0 by atan(2^-IDX) and accumulates the angle.
// ----------------------------------------------------------------------------
module qte_cordic_cell
  import qte_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic    clk,
  input  logic    en,
  input  cordic_t din,
  output cordic_t dout
);

  localparam logic signed [DW-1:0] ANG = ATAN_TBL[IDX % TBL_N];

  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;
  cordic_t              nxt;

  always_comb begin
    dx       = din.y >>> IDX;
    dy       = din.x >>> IDX;
    nxt.zero = din.zero;
    if (!din.y[DW-1]) begin
      nxt.x = din.x + dx;
      nxt.y = din.y - dy;
      nxt.z = din.z + ANG;
    end else begin
      nxt.x = din.x - dx;
      nxt.y = din.y + dy;
      nxt.z = din.z - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

[rtl/quaternion_to_euler_angles_unit.sv]
// Throughput: one request per cycle; the whole pipeline stalls together
// only while a finished result waits at the output register.
// Length is set by the 31-cell square root chain plus the CORDIC cell rows.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_unit: quaternion to yaw, pitch, roll
// Products, lock detect, square root cell chain, three CORDIC cell rows,
// rounding and output register.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_unit
  import qte_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  qte_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output qte_out_t out_data
);

  localparam int LAT = 4 + SQ_CELLS + 1 + CORDIC_STAGES;

  logic           en;
  logic [LAT-1:0] vld;

  // stage 1: products
  logic signed [2*QW-1:0] p_yw, p_xz, p_xy, p_zw, p_yz, p_xw;
  logic signed [2*QW-1:0] p_sx, p_sy, p_sz, p_sw;
  logic signed [QW-1:0]   s1_x, s1_w;

  // stage 2: test value, lock, CORDIC operands
  logic signed [DW-1:0] t_c;
  side_t                side_c;
  side_t                side2, side3;

  // stage 3/4: square and remainder
  logic signed [30:0]    t31;
  logic signed [61:0]    tsq;
  sqrt_t                 sq_q [SQ_CELLS+1];
  side_t                 side_q [SQ_CELLS+1];

  // CORDIC rows
  cordic_t roll_c  [CORDIC_STAGES+1];
  cordic_t yaw_c   [CORDIC_STAGES+1];
  cordic_t pitch_c [CORDIC_STAGES+1];
  lock_t   lk_q    [CORDIC_STAGES+1];

  logic signed [DW+1:0] roll_z, yaw_z, pitch_z;
  qte_out_t             out_next;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_yw <= in_data.quat_y * in_data.quat_w;
      p_xz <= in_data.quat_x * in_data.quat_z;
      p_xy <= in_data.quat_x * in_data.quat_y;
      p_zw <= in_data.quat_z * in_data.quat_w;
      p_yz <= in_data.quat_y * in_data.quat_z;
      p_xw <= in_data.quat_x * in_data.quat_w;
      p_sx <= in_data.quat_x * in_data.quat_x;
      p_sy <= in_data.quat_y * in_data.quat_y;
      p_sz <= in_data.quat_z * in_data.quat_z;
      p_sw <= in_data.quat_w * in_data.quat_w;
      s1_x <= in_data.quat_x;
      s1_w <= in_data.quat_w;
    end
  end

  always_comb begin
    t_c      = (DW'(p_yw) - DW'(p_xz)) <<< 1;
    side_c.t = t_c;
    if (t_c >= ONE_Q30) begin
      side_c.lock = LOCK_NORTH;
    end else if (t_c <= -ONE_Q30) begin
      side_c.lock = LOCK_SOUTH;
    end else begin
      side_c.lock = LOCK_NONE;
    end
    if (side_c.lock != LOCK_NONE) begin
      side_c.roll_y = DW'(s1_x) <<< 15;
      side_c.roll_x = DW'(s1_w) <<< 15;
    end else begin
      side_c.roll_y = (DW'(p_xy) + DW'(p_zw)) <<< 1;
      side_c.roll_x = DW'(p_sx) - DW'(p_sy) - DW'(p_sz) + DW'(p_sw);
    end
    side_c.yaw_y = (DW'(p_yz) + DW'(p_xw)) <<< 1;
    side_c.yaw_x = DW'(p_sz) + DW'(p_sw) - DW'(p_sx) - DW'(p_sy);
  end

  assign t31 = side2.t[30:0];

  always_ff @(posedge clk) begin
    if (en) begin
      side2        <= side_c;
      tsq          <= t31 * t31;
      side3        <= side2;
      sq_q[0].n    <= (SQW'(1) << 60) - SQW'(tsq);
      sq_q[0].res  <= '0;
      side_q[0]    <= side3;
    end
  end

  for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sqrt
    qte_sqrt_cell #(.K(SQ_CELLS - 1 - k)) u_cell (
      .clk  (clk),
      .en   (en),
      .din  (sq_q[k]),
      .dout (sq_q[k+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        side_q[k+1] <= side_q[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll_c[0]  <= cordic_pre(side_q[SQ_CELLS].roll_y, side_q[SQ_CELLS].roll_x);
      yaw_c[0]   <= cordic_pre(side_q[SQ_CELLS].yaw_y, side_q[SQ_CELLS].yaw_x);
      pitch_c[0] <= cordic_pre(side_q[SQ_CELLS].t,
                               signed'(sq_q[SQ_CELLS].res[DW-1:0]));
      lk_q[0]    <= side_q[SQ_CELLS].lock;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    qte_cordic_cell #(.IDX(i)) u_roll (
      .clk  (clk),
      .en   (en),
      .din  (roll_c[i]),
      .dout (roll_c[i+1])
    );
    qte_cordic_cell #(.IDX(i)) u_yaw (
      .clk  (clk),
      .en   (en),
      .din  (yaw_c[i]),
      .dout (yaw_c[i+1])
    );
    qte_cordic_cell #(.IDX(i)) u_pitch (
      .clk  (clk),
      .en   (en),
      .din  (pitch_c[i]),
      .dout (pitch_c[i+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        lk_q[i+1] <= lk_q[i];
      end
    end
  end

  always_comb begin
    roll_z  = roll_c[CORDIC_STAGES].zero  ? '0 : (DW+2)'(roll_c[CORDIC_STAGES].z);
    yaw_z   = yaw_c[CORDIC_STAGES].zero   ? '0 : (DW+2)'(yaw_c[CORDIC_STAGES].z);
    pitch_z = pitch_c[CORDIC_STAGES].zero ? '0 : (DW+2)'(pitch_c[CORDIC_STAGES].z);
    out_next.lock_case = lk_q[CORDIC_STAGES];
    unique case (lk_q[CORDIC_STAGES])
      LOCK_NORTH: begin
        out_next.yaw   = '0;
        out_next.pitch = angle_out((DW+2)'(HALF_PI_Q30));
        out_next.roll  = angle_out(-(roll_z <<< 1));
      end
      LOCK_SOUTH: begin
        out_next.yaw   = '0;
        out_next.pitch = angle_out(-(DW+2)'(HALF_PI_Q30));
        out_next.roll  = angle_out(roll_z <<< 1);
      end
      default: begin
        out_next.yaw   = angle_out(yaw_z);
        out_next.pitch = angle_out(pitch_z);
        out_next.roll  = angle_out(roll_z);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= out_next;
    end
  end

`ifndef SYNTH
  a_lock_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.lock_case != 2'd3)
    else $error("invalid lock code on output");

  a_north_pitch: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.lock_case == LOCK_NORTH |->
      out_data.yaw == '0 && out_data.pitch == angle_out((DW+2)'(HALF_PI_Q30)))
    else $error("north lock angles wrong");

  a_south_pitch: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.lock_case == LOCK_SOUTH |->
      out_data.yaw == '0 && out_data.pitch == angle_out(-(DW+2)'(HALF_PI_Q30)))
    else $error("south lock angles wrong");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: quaternion to Euler angle unit testbench
// Directed extremes and gimbal lock edges, then random unit, raw and near-lock
// quaternions under three idle patterns; every result is checked against
// an integer CORDIC predictor.
// ----------------------------------------------------------------------------
module tb;
  import qte_pkg::*;

  localparam int STAGES = 16;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_ready;
  qte_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  qte_out_t out_data;

  qte_out_t angles_due[$];
  int       send_idle = 0;
  int       recv_idle = 0;
  int       errors = 0;
  int       n_sent = 0;
  int       n_checked = 0;
  int       n_lock = 0;

  quaternion_to_euler_angles_unit #(.CORDIC_STAGES(STAGES)) uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  localparam longint ONE30  = 64'sd1073741824;
  localparam longint PI30   = 64'sd3373259426;
  localparam longint HPI30  = 64'sd1686629713;
  localparam longint ANG_TBL [16] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767
  };

  function automatic longint vec_angle(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PI30 : -PI30;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ANG_TBL[i];
      end else begin
        x -= dx; y += dy; z -= ANG_TBL[i];
      end
    end
    return z;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] to_q312(longint z);
    longint v;
    v = (z + (64'sd1 <<< 17)) >>> 18;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic qte_out_t euler_of(qte_in_t q);
    qte_out_t r;
    longint y, x, zc, w, t, yaw, pitch, roll, sx, sy, sz, sw;
    longint unsigned rem;
    y = longint'(q.quat_y); x = longint'(q.quat_x);
    zc = longint'(q.quat_z); w = longint'(q.quat_w);
    t = 2 * (y * w - x * zc);
    if (t >= ONE30) begin
      roll = -2 * vec_angle(x * 32768, w * 32768);
      yaw = 0; pitch = HPI30; r.lock_case = LOCK_NORTH;
    end else if (t <= -ONE30) begin
      roll = 2 * vec_angle(x * 32768, w * 32768);
      yaw = 0; pitch = -HPI30; r.lock_case = LOCK_SOUTH;
    end else begin
      sx = x * x; sy = y * y; sz = zc * zc; sw = w * w;
      rem = longint'(ONE30 * ONE30) - longint'(t * t);
      roll = vec_angle(2 * (x * y + zc * w), sx - sy - sz + sw);
      yaw = vec_angle(2 * (y * zc + x * w), -sx - sy + sz + sw);
      pitch = vec_angle(t, longint'(root_floor(rem)));
      r.lock_case = LOCK_NONE;
    end
    r.yaw = to_q312(yaw);
    r.pitch = to_q312(pitch);
    r.roll = to_q312(roll);
    return r;
  endfunction

  task automatic send_quat(input logic [15:0] qy, qx, qz, qw);
    qte_in_t q;
    q = {qy, qx, qz, qw};
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= q;
    do @(posedge clk); while (!in_ready);
    angles_due.push_back(euler_of(q));
    n_sent++;
    if (euler_of(q).lock_case != LOCK_NONE) n_lock++;
    @(negedge clk);
  endtask

  always @(negedge clk)
    out_ready <= !rst && ($urandom_range(99) >= recv_idle);

  always @(posedge clk) begin
    qte_out_t e;
    if (!rst && out_valid && out_ready) begin
      if (angles_due.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        e = angles_due.pop_front();
        n_checked++;
        if (out_data.yaw !== e.yaw)
          $display("%0t: yaw expected %0d got %0d", $time, e.yaw, out_data.yaw);
        if (out_data.pitch !== e.pitch)
          $display("%0t: pitch expected %0d got %0d", $time, e.pitch, out_data.pitch);
        if (out_data.roll !== e.roll)
          $display("%0t: roll expected %0d got %0d", $time, e.roll, out_data.roll);
        if (out_data.lock_case !== e.lock_case)
          $display("%0t: lock expected %0d got %0d", $time, e.lock_case,
                   out_data.lock_case);
        if (out_data !== e) errors++;
      end
    end
  end

  task automatic test_directed();
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send_quat(16'h7fff, 16'h0000, 16'h0000, 16'h7fff);
    send_quat(16'h7fff, 16'h0000, 16'h0000, 16'h8001);
    send_quat(16'h7fff, 16'h1000, 16'h0000, 16'h7fff);
    send_quat(16'h7fff, 16'hc000, 16'h0000, 16'h8001);
    send_quat(16'h0000, 16'h4000, 16'h8000, 16'h0000);  // t exactly +1
    send_quat(16'h0000, 16'hc000, 16'h8000, 16'h0000);  // t exactly -1
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h7fff);
    send_quat(16'h0000, 16'h7fff, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h7fff, 16'h0000);
    send_quat(16'h7fff, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h8000);
    send_quat(16'h5a82, 16'h0000, 16'h0000, 16'h5a82);
    send_quat(16'h5a82, 16'h0000, 16'h0000, 16'h5a81);
    send_quat(16'h0001, 16'hffff, 16'h0001, 16'hffff);
    send_quat(16'h4000, 16'h4000, 16'hc000, 16'h4000);
  endtask

  task automatic test_random(input int count);
    real c[4], nrm;
    logic [15:0] v[4];
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(9))
        0, 1: begin
          for (int i = 0; i < 4; i++) v[i] = 16'($urandom);
        end
        2: begin  // near gimbal lock
          v[0] = 16'(16'h5a82 + $urandom_range(40) - 20);
          v[3] = 16'(($urandom_range(1) ? 16'h5a82 : 16'ha57e) + $urandom_range(40) - 20);
          v[1] = 16'($urandom_range(200) - 100);
          v[2] = 16'($urandom_range(200) - 100);
        end
        default: begin
          nrm = 0.0;
          for (int i = 0; i < 4; i++) begin
            c[i] = real'($urandom_range(20000)) - 10000.0;
            nrm += c[i] * c[i];
          end
          if (nrm == 0.0) nrm = 1.0;
          nrm = $sqrt(nrm);
          for (int i = 0; i < 4; i++) v[i] = 16'($rtoi(c[i] / nrm * 32767.0));
        end
      endcase
      send_quat(v[0], v[1], v[2], v[3]);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle = 8; recv_idle = 83;
    test_directed();
    test_random(520);
    send_idle = 83; recv_idle = 8;
    test_random(530);
    send_idle = 0; recv_idle = 0;
    test_random(530);
    in_valid <= 1'b0;
    wait (angles_due.size() == 0);
    repeat (80) @(posedge clk);
    $display("tb: %0d quaternions sent, %0d results checked, %0d in gimbal lock",
             n_sent, n_checked, n_lock);
    $display("tb: directed extremes plus random unit, raw and near-lock inputs");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
